/* sv/sorted_chunk_key_table_unit_macros.svh */
// assertion macros for the sorted chunk key table unit
// depends on i_clk and i_rst_n being visible in the module that uses them
`ifndef SORTED_CHUNK_KEY_TABLE_UNIT_MACROS_SVH
`define SORTED_CHUNK_KEY_TABLE_UNIT_MACROS_SVH

// same-cycle implication, switched off while in reset
`define SCKT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, switched off while in reset
`define SCKT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sckt_pkg.sv */
// shared types, codes and sizes for the sorted chunk key table unit
// no dependencies
package sckt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int COORD_W     = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    // opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_PRUNE  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_PRESENT   = 3'd1;
    localparam logic [2:0] ST_DELETED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_PRUNED    = 3'd5;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [COORD_W-1:0] key_x;
        logic signed [COORD_W-1:0] key_y;
    } t_cmd;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] slot_index;
        logic [8:0] entry_count;
        logic [8:0] removed_count;
        logic       changed_flag;
    } t_result;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_entry;

    // low bits of a count or position for the result fields
    function automatic logic [8:0] fn_cnt9(input logic [CNT_W-1:0] c);
        logic [CNT_W+8:0] v;
        v = {{9{1'b0}}, c};
        return v[8:0];
    endfunction

    function automatic logic [7:0] fn_slot8(input logic [CNT_W-1:0] c);
        logic [CNT_W+7:0] v;
        v = {{8{1'b0}}, c};
        return v[7:0];
    endfunction

endpackage

/* sv/sorted_chunk_key_table_unit.sv */
// sorted chunk key table: sorted (x,y) key store with insert, delete and prune
// depends on sckt_pkg and sorted_chunk_key_table_unit_macros.svh
//
// Usage
//   Command channel: present i_cmd with start high while busy is low; that
//   edge is the transfer. busy then stays high until a valid command is done.
//   Result channel: o_done is high for exactly one cycle with o_result; the
//   receiver cannot stall it and must take it in that cycle.
//   Config: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 width,
//   1 height) at the clock edge; write only while the block is idle.
// Sequence: insert and delete run a binary search over the n keys held, at
//   most ceil(log2(n+1)) probes, then read the lower bound for the equality
//   check. insert then shifts the entries from the lower bound up by one, top
//   entry first, and writes the key into the gap; delete moves each later entry
//   down by one; prune scans every entry once and compacts the kept ones; an
//   unused opcode is answered from idle with status not found, busy staying low.
//   Each probe is a read state then a compare state; every shift or scan
//   moves one entry a cycle through the registered read port.
//   busy drops in the cycle the result is shown, so a new command may be
//   issued then.
// Reset: i_rst_n low clears the key count, the changed flag and the sequencer
//   and restores width 16, height 8. The key memory itself is not cleared;
//   only entries below the count are ever used.
module sorted_chunk_key_table_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  sckt_pkg::t_cmd                  i_cmd,
    output logic                            busy,
    output logic                            o_done,
    output sckt_pkg::t_result               o_result,
    input  logic                            i_cfg_we,
    input  logic [sckt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sckt_pkg::CFG_W-1:0]      i_cfg_data
);
    import sckt_pkg::*;

    localparam int EXT_W = COORD_W + 2;
    localparam logic [CNT_W-1:0]        DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0]        ONE_C   = CNT_W'(1);
    localparam logic signed [EXT_W-1:0] ONE_E   = EXT_W'(1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BS_RD  = 3'd1;
    localparam logic [2:0] S_BS_CMP = 3'd2;
    localparam logic [2:0] S_EQ_CMP = 3'd3;
    localparam logic [2:0] S_INS    = 3'd4;
    localparam logic [2:0] S_DEL    = 3'd5;
    localparam logic [2:0] S_PRN    = 3'd6;

    logic [2:0]                r_state,   n_state;
    logic [1:0]                r_op,      n_op;
    logic signed [COORD_W-1:0] r_kx,      n_kx;
    logic signed [COORD_W-1:0] r_ky,      n_ky;
    logic signed [EXT_W-1:0]   r_xr,      n_xr;
    logic signed [EXT_W-1:0]   r_ytop,    n_ytop;
    logic [CNT_W-1:0]          r_lo,      n_lo;
    logic [CNT_W-1:0]          r_hi,      n_hi;
    logic [CNT_W-1:0]          r_idx,     n_idx;
    logic [CNT_W-1:0]          r_wptr,    n_wptr;
    logic [CNT_W-1:0]          r_removed, n_removed;
    logic [CNT_W-1:0]          r_count,   n_count;
    logic                      r_dirty,   n_dirty;
    logic                      r_pend,    n_pend;
    logic [ADDR_W-1:0]         r_waddr,   n_waddr;
    logic [CFG_W-1:0]          r_width;
    logic [CFG_W-1:0]          r_height;
    logic                      r_done,    n_done;
    t_result                   r_result,  n_result;
    t_entry                    r_rdata;

    t_entry                    mem [TABLE_DEPTH];
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    t_entry                    mem_wdata;
    logic                      mem_re;
    logic [ADDR_W-1:0]         mem_raddr;

    logic [CNT_W:0]            w_sum;
    logic [CNT_W-1:0]          w_mid;
    logic [CNT_W-1:0]          w_idx_dec;
    logic signed [EXT_W-1:0]   w_kx_e;
    logic signed [EXT_W-1:0]   w_ky_e;
    logic signed [EXT_W-1:0]   w_x_e;
    logic signed [EXT_W-1:0]   w_y_e;
    logic signed [EXT_W-1:0]   w_half_e;
    logic signed [EXT_W-1:0]   w_height_e;
    logic                      c_less;
    logic                      c_equal;
    logic                      c_keep;
    logic                      w_present;
    t_entry                    w_key;

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    assign w_sum     = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_sum[CNT_W:1];
    assign w_idx_dec = r_idx - ONE_C;
    assign w_key     = '{x: r_kx, y: r_ky};

    // shared compare unit on the word just read
    assign c_less  = (r_rdata.x < r_kx) || ((r_rdata.x == r_kx) && (r_rdata.y < r_ky));
    assign c_equal = (r_rdata.x == r_kx) && (r_rdata.y == r_ky);
    assign w_x_e   = {{2{r_rdata.x[COORD_W-1]}}, r_rdata.x};
    assign w_y_e   = {{2{r_rdata.y[COORD_W-1]}}, r_rdata.y};
    assign c_keep  = !((w_x_e < w_kx_e) || (w_x_e >= r_xr) ||
                       (w_y_e < w_ky_e) || (w_y_e > r_ytop));
    assign w_present = (r_lo < r_count) && c_equal;

    // borders are widened so they never wrap
    assign w_kx_e     = {{2{r_kx[COORD_W-1]}}, r_kx};
    assign w_ky_e     = {{2{r_ky[COORD_W-1]}}, r_ky};
    assign w_half_e   = {{(EXT_W-CFG_W+1){1'b0}}, r_width[CFG_W-1:1]};
    assign w_height_e = {{(EXT_W-CFG_W){1'b0}}, r_height};

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_kx      = r_kx;
        n_ky      = r_ky;
        n_xr      = r_xr;
        n_ytop    = r_ytop;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_idx     = r_idx;
        n_wptr    = r_wptr;
        n_removed = r_removed;
        n_count   = r_count;
        n_dirty   = r_dirty;
        n_pend    = r_pend;
        n_waddr   = r_waddr;
        n_done    = 1'b0;
        n_result  = r_result;
        mem_we    = 1'b0;
        mem_waddr = r_waddr;
        mem_wdata = r_rdata;
        mem_re    = 1'b0;
        mem_raddr = r_idx[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op   = i_cmd.opcode;
                    n_kx   = i_cmd.key_x;
                    n_ky   = i_cmd.key_y;
                    n_lo   = '0;
                    n_hi   = r_count;
                    n_pend = 1'b0;
                    case (i_cmd.opcode) inside
                        OP_INSERT, OP_DELETE: begin
                            n_state = S_BS_RD;
                        end
                        OP_PRUNE: begin
                            n_state   = S_PRN;
                            n_idx     = '0;
                            n_wptr    = '0;
                            n_removed = '0;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_result = '{status: ST_NOT_FOUND, slot_index: 8'd0,
                                         entry_count: fn_cnt9(r_count),
                                         removed_count: 9'd0, changed_flag: r_dirty};
                        end
                    endcase
                end
            end
            S_BS_RD: begin
                mem_re = 1'b1;
                if (r_lo < r_hi) begin
                    mem_raddr = w_mid[ADDR_W-1:0];
                    n_state   = S_BS_CMP;
                end else begin
                    // probe the lower bound itself for the equality check
                    mem_raddr = r_lo[ADDR_W-1:0];
                    n_state   = S_EQ_CMP;
                end
            end
            S_BS_CMP: begin
                if (c_less) begin
                    n_lo = w_mid + ONE_C;
                end else begin
                    n_hi = w_mid;
                end
                n_state = S_BS_RD;
            end
            S_EQ_CMP: begin
                case (r_op)
                    OP_INSERT: begin
                        if (w_present) begin
                            n_state  = S_IDLE;
                            n_done   = 1'b1;
                            n_result = '{status: ST_PRESENT, slot_index: fn_slot8(r_lo),
                                         entry_count: fn_cnt9(r_count),
                                         removed_count: 9'd0, changed_flag: r_dirty};
                        end else if (r_count >= DEPTH_C) begin
                            n_state  = S_IDLE;
                            n_done   = 1'b1;
                            n_result = '{status: ST_FULL, slot_index: 8'd0,
                                         entry_count: fn_cnt9(r_count),
                                         removed_count: 9'd0, changed_flag: r_dirty};
                        end else begin
                            n_idx   = r_count;
                            n_state = S_INS;
                        end
                    end
                    default: begin
                        if (w_present) begin
                            n_idx   = r_lo + ONE_C;
                            n_state = S_DEL;
                        end else begin
                            n_state  = S_IDLE;
                            n_done   = 1'b1;
                            n_result = '{status: ST_NOT_FOUND, slot_index: 8'd0,
                                         entry_count: fn_cnt9(r_count),
                                         removed_count: 9'd0, changed_flag: r_dirty};
                        end
                    end
                endcase
            end
            S_INS: begin
                // open a gap at the lower bound, top entry first
                if (r_pend) begin
                    mem_we = 1'b1;
                end
                if (r_idx > r_lo) begin
                    mem_re    = 1'b1;
                    mem_raddr = w_idx_dec[ADDR_W-1:0];
                    n_pend    = 1'b1;
                    n_waddr   = r_idx[ADDR_W-1:0];
                    n_idx     = w_idx_dec;
                end else if (!r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_lo[ADDR_W-1:0];
                    mem_wdata = w_key;
                    n_count   = r_count + ONE_C;
                    n_dirty   = 1'b1;
                    n_state   = S_IDLE;
                    n_done    = 1'b1;
                    n_result  = '{status: ST_INSERTED, slot_index: fn_slot8(r_lo),
                                  entry_count: fn_cnt9(r_count + ONE_C),
                                  removed_count: 9'd0, changed_flag: 1'b1};
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_DEL: begin
                // close the gap, moving each later entry down by one
                if (r_pend) begin
                    mem_we = 1'b1;
                end
                if (r_idx < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx[ADDR_W-1:0];
                    n_pend    = 1'b1;
                    n_waddr   = w_idx_dec[ADDR_W-1:0];
                    n_idx     = r_idx + ONE_C;
                end else if (!r_pend) begin
                    n_count  = r_count - ONE_C;
                    n_dirty  = 1'b1;
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_result = '{status: ST_DELETED, slot_index: fn_slot8(r_lo),
                                 entry_count: fn_cnt9(r_count - ONE_C),
                                 removed_count: 9'd0, changed_flag: 1'b1};
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_PRN: begin
                // compact kept entries towards the bottom in one pass
                if (r_pend) begin
                    if (c_keep) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_wptr[ADDR_W-1:0];
                        n_wptr    = r_wptr + ONE_C;
                    end else begin
                        n_removed = r_removed + ONE_C;
                    end
                end
                if (r_idx < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx[ADDR_W-1:0];
                    n_pend    = 1'b1;
                    n_idx     = r_idx + ONE_C;
                end else if (!r_pend) begin
                    n_count  = r_wptr;
                    n_dirty  = 1'b0;
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_result = '{status: ST_PRUNED, slot_index: 8'd0,
                                 entry_count: fn_cnt9(r_wptr),
                                 removed_count: fn_cnt9(r_removed), changed_flag: 1'b0};
                end else begin
                    n_pend = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_pend  = 1'b0;
            end
        endcase

        // window borders for a prune, fixed for the whole pass
        if (r_state == S_IDLE) begin
            n_xr   = {{2{i_cmd.key_x[COORD_W-1]}}, i_cmd.key_x} + ONE_E + w_half_e;
            n_ytop = {{2{i_cmd.key_y[COORD_W-1]}}, i_cmd.key_y} + w_height_e - ONE_E;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_dirty  <= 1'b0;
            r_pend   <= 1'b0;
            r_done   <= 1'b0;
            r_width  <= CFG_W'(16);
            r_height <= CFG_W'(8);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_dirty <= n_dirty;
            r_pend  <= n_pend;
            r_done  <= n_done;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_kx      <= n_kx;
        r_ky      <= n_ky;
        r_xr      <= n_xr;
        r_ytop    <= n_ytop;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_idx     <= n_idx;
        r_wptr    <= n_wptr;
        r_removed <= n_removed;
        r_waddr   <= n_waddr;
        r_result  <= n_result;
    end

    // key memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

`include "sorted_chunk_key_table_unit_macros.svh"

    `SCKT_ASSERT_IMP(a_done_when_idle, o_done, !busy, "result shown while still busy")
    `SCKT_ASSERT_NXT(a_start_progress, start && !busy, busy || o_done,
                     "accepted command neither running nor answered")
    `SCKT_ASSERT_IMP(a_count_bound, 1'b1, r_count <= DEPTH_C, "key count beyond table depth")
    `SCKT_ASSERT_IMP(a_idle_no_pend, r_state == S_IDLE, !r_pend,
                     "memory move pending while idle")
    `SCKT_ASSERT_IMP(a_prune_clears, o_done && (o_result.status == ST_PRUNED),
                     !o_result.changed_flag, "prune left changed flag set")
    `SCKT_ASSERT_IMP(a_count_out, o_done, o_result.entry_count == fn_cnt9(r_count),
                     "reported count differs from held count")

endmodule

/* tb/sorted_chunk_key_table_unit_tb.sv */
// self-checking testbench for the sorted chunk key table unit: directed and random
// insert, delete and prune commands checked against a shadow table; depends on sckt_pkg
module sorted_chunk_key_table_unit_tb;
    import sckt_pkg::*;

    localparam logic [1:0] OP_NONE       = 2'd3;
    localparam int         RESET_WIDTH   = 16;
    localparam int         RESET_HEIGHT  = 8;
    localparam int         STALL_LIMIT   = 4000;
    localparam int         SETTLE_CYCLES = 300;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    t_cmd                 i_cmd      = '0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 busy;
    logic                 o_done;
    t_result              o_result;

    // shadow copy of the table and the window registers
    int         shadow_x [TABLE_DEPTH];
    int         shadow_y [TABLE_DEPTH];
    int         shadow_count;
    logic       shadow_dirty;
    logic [7:0] win_width;
    logic [7:0] win_height;

    t_cmd    cmd_queue[$];
    t_result pending_results[$];
    logic    cmd_taken    = 1'b0;
    logic    quiet_tail   = 1'b0;
    int      idle_pct     = 50;
    int      gap_left     = 0;
    int      stall_cycles = 0;
    int      mismatch_count  = 0;
    int      cmds_sent       = 0;
    int      results_checked = 0;
    int      status_seen [8];

    sorted_chunk_key_table_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_cmd      (i_cmd),
        .busy       (busy),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // applies one command to the shadow table and returns the answer it should give
    function automatic t_result apply_table_op(input t_cmd c);
        t_result r;
        int      kx, ky, pos, i, kept, xr, ytop, ww, wh;
        logic    hit;
        kx = $signed(c.key_x);
        ky = $signed(c.key_y);
        r = '0;
        r.status = ST_NOT_FOUND;
        pos = 0;
        while (pos < shadow_count && (shadow_x[pos] < kx ||
               (shadow_x[pos] == kx && shadow_y[pos] < ky)))
            pos++;
        hit = (pos < shadow_count) && shadow_x[pos] == kx && shadow_y[pos] == ky;
        case (c.opcode)
            OP_INSERT: begin
                if (hit) begin
                    r.status = ST_PRESENT;
                    r.slot_index = 8'(pos);
                end else if (shadow_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = shadow_count; i > pos; i--) begin
                        shadow_x[i] = shadow_x[i-1];
                        shadow_y[i] = shadow_y[i-1];
                    end
                    shadow_x[pos] = kx;
                    shadow_y[pos] = ky;
                    shadow_count++;
                    shadow_dirty = 1'b1;
                    r.status = ST_INSERTED;
                    r.slot_index = 8'(pos);
                end
            end
            OP_DELETE: begin
                if (hit) begin
                    for (i = pos; i + 1 < shadow_count; i++) begin
                        shadow_x[i] = shadow_x[i+1];
                        shadow_y[i] = shadow_y[i+1];
                    end
                    shadow_count--;
                    shadow_dirty = 1'b1;
                    r.status = ST_DELETED;
                    r.slot_index = 8'(pos);
                end
            end
            OP_PRUNE: begin
                // borders in int so the window never wraps
                ww = win_width;
                wh = win_height;
                xr = kx + 1 + (ww >> 1);
                ytop = ky + wh - 1;
                kept = 0;
                for (i = 0; i < shadow_count; i++) begin
                    if (shadow_x[i] < kx || shadow_x[i] >= xr ||
                        shadow_y[i] < ky || shadow_y[i] > ytop) begin
                        r.removed_count++;
                    end else begin
                        shadow_x[kept] = shadow_x[i];
                        shadow_y[kept] = shadow_y[i];
                        kept++;
                    end
                end
                shadow_count = kept;
                shadow_dirty = 1'b0;
                r.status = ST_PRUNED;
            end
            default: begin
            end
        endcase
        r.entry_count = 9'(shadow_count);
        r.changed_flag = shadow_dirty;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s of result %0d: expected %0d, got %0d",
                     field, results_checked, want, got);
    endtask

    task automatic queue_cmd(input logic [1:0] op, input int x, input int y);
        t_cmd c;
        c.opcode = op;
        c.key_x = 16'(x);
        c.key_y = 16'(y);
        cmd_queue.push_back(c);
    endtask

    // mostly keys around a cluster centre so deletes and prunes find something
    task automatic queue_random_cmd(input int cx, input int cy);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            queue_cmd(OP_INSERT, cx + $urandom_range(0, 16) - 6, cy + $urandom_range(0, 16) - 6);
        else if (pick < 75)
            queue_cmd(OP_DELETE, cx + $urandom_range(0, 16) - 6, cy + $urandom_range(0, 16) - 6);
        else if (pick < 88)
            queue_cmd(OP_PRUNE, cx + $urandom_range(0, 8) - 6, cy + $urandom_range(0, 8) - 6);
        else if (pick < 92)
            queue_cmd(OP_NONE, $urandom_range(0, 65535), $urandom_range(0, 65535));
        else
            queue_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
    endtask

    function automatic int pick_centre();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return -32762;
            2: return 32760;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic wait_table_idle();
        do @(negedge i_clk);
        while (cmd_queue.size() != 0 || start || cmd_taken || pending_results.size() != 0);
    endtask

    task automatic set_window(input int w, input int h);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_WIDTH;
        i_cfg_data <= 8'(w);
        @(negedge i_clk);
        i_cfg_idx  <= REG_HEIGHT;
        i_cfg_data <= 8'(h);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // command driver: one transfer at a time, random gaps between them
    always @(negedge i_clk) begin : drive_cmds
        logic nxt_start;
        t_cmd nxt_cmd;
        nxt_start = start;
        nxt_cmd = i_cmd;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else begin
            if (cmd_taken) begin
                nxt_start = 1'b0;
                cmd_taken = 1'b0;
                if (!quiet_tail && $urandom_range(0, 99) < idle_pct)
                    gap_left = $urandom_range(1, 18);
            end
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_queue.size() != 0) begin
                    nxt_cmd = cmd_queue.pop_front();
                    nxt_start = 1'b1;
                end
            end
        end
        start <= nxt_start;
        i_cmd <= nxt_cmd;
    end

    // result checks, register tracking and prediction at each accepted command
    always @(posedge i_clk) begin : watch_ports
        t_result want;
        if (!i_rst_n) begin
            shadow_count = 0;
            shadow_dirty = 1'b0;
            win_width = 8'(RESET_WIDTH);
            win_height = 8'(RESET_HEIGHT);
        end else begin
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result with nothing expected: status %0d count %0d",
                                 o_result.status, o_result.entry_count);
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.status !== want.status)
                        note_mismatch("status", want.status, o_result.status);
                    if (o_result.slot_index !== want.slot_index)
                        note_mismatch("slot_index", want.slot_index, o_result.slot_index);
                    if (o_result.entry_count !== want.entry_count)
                        note_mismatch("entry_count", want.entry_count, o_result.entry_count);
                    if (o_result.removed_count !== want.removed_count)
                        note_mismatch("removed_count", want.removed_count,
                                      o_result.removed_count);
                    if (o_result.changed_flag !== want.changed_flag)
                        note_mismatch("changed_flag", want.changed_flag, o_result.changed_flag);
                    results_checked++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDTH:  win_width = i_cfg_data;
                    REG_HEIGHT: win_height = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (start && !busy) begin
                want = apply_table_op(i_cmd);
                pending_results.push_back(want);
                status_seen[want.status]++;
                cmd_taken = 1'b1;
                cmds_sent++;
            end
        end
    end

    // ends the run when neither channel has moved for too long
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || o_done || (start && !busy))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        int cx, cy, mul, off, idx, i, ph, n, fx, fy;
        int set_w [6];
        int set_h [6];

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset window of 16 by 8
        queue_cmd(OP_PRUNE, 0, 0);                 // prune of an empty table
        queue_cmd(OP_DELETE, 5, 5);                // delete on an empty table
        queue_cmd(OP_NONE, -1, -1);
        queue_cmd(OP_INSERT, 0, 0);
        queue_cmd(OP_INSERT, 0, 0);                // already present
        queue_cmd(OP_INSERT, -32768, -32768);
        queue_cmd(OP_INSERT, 32767, 32767);
        queue_cmd(OP_INSERT, -32768, 32767);
        queue_cmd(OP_INSERT, 32767, -32768);
        queue_cmd(OP_INSERT, 0, -1);
        queue_cmd(OP_INSERT, -1, 0);
        queue_cmd(OP_INSERT, -1, -1);
        queue_cmd(OP_DELETE, 0, 0);
        queue_cmd(OP_DELETE, 0, 0);                // absent key
        queue_cmd(OP_DELETE, -32768, 32767);
        queue_cmd(OP_NONE, 32767, -32768);
        queue_cmd(OP_PRUNE, -32768, -32768);       // window at the low corner
        queue_cmd(OP_INSERT, 32767, 32767);
        queue_cmd(OP_INSERT, 32767, 32766);
        queue_cmd(OP_PRUNE, 32767, 32760);         // x border past the top of the range
        queue_cmd(OP_DELETE, 32767, 32767);
        queue_cmd(OP_PRUNE, 32767, 32767);
        wait_table_idle();

        // zero height empties the table whatever the origin
        set_window(255, 0);
        queue_cmd(OP_INSERT, 3, 3);
        queue_cmd(OP_INSERT, -3, -3);
        queue_cmd(OP_PRUNE, -100, -100);
        wait_table_idle();

        // fill to the last slot in scrambled order, then hit the full table
        set_window(0, 1);
        idle_pct = 20;
        cx = $urandom_range(0, 65535);
        cy = $urandom_range(0, 65535);
        mul = 2 * $urandom_range(0, 127) + 1;
        off = $urandom_range(0, 255);
        for (i = 0; i < TABLE_DEPTH; i++) begin
            idx = (i * mul + off) & 255;
            queue_cmd(OP_INSERT, cx + (idx >> 4), cy + (idx & 15));
        end
        fx = cx + (off >> 4);
        fy = cy + (off & 15);
        queue_cmd(OP_INSERT, cx + 16, cy);
        queue_cmd(OP_INSERT, fx, fy);
        queue_cmd(OP_NONE, fx, fy);
        queue_cmd(OP_DELETE, fx, fy);
        queue_cmd(OP_INSERT, cx - 1, cy);
        queue_cmd(OP_INSERT, cx + 16, cy + 1);
        queue_cmd(OP_PRUNE, cx + 3, cy + 5);
        wait_table_idle();

        // random phases over several window settings, the last one without gaps
        set_w = '{16, 255, 0, 1, 0, 0};
        set_h = '{8, 255, 0, 1, 0, 255};
        set_w[2] = $urandom_range(0, 255);
        set_h[2] = $urandom_range(0, 255);
        set_w[4] = $urandom_range(0, 255);
        set_h[4] = $urandom_range(1, 255);
        for (ph = 0; ph < 6; ph++) begin
            set_window(set_w[ph], set_h[ph]);
            idle_pct = (ph % 2 == 0) ? 60 : 0;
            if (ph == 5)
                quiet_tail = 1'b1;
            cx = pick_centre();
            cy = pick_centre();
            for (n = 0; n < 45; n++)
                queue_random_cmd(cx, cy);
            wait_table_idle();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        mismatch_count += pending_results.size();
        $display("%0d commands sent, %0d results checked over 9 window settings",
                 cmds_sent, results_checked);
        $display("inserted %0d, present %0d, deleted %0d, not found %0d, full %0d, pruned %0d",
                 status_seen[ST_INSERTED], status_seen[ST_PRESENT], status_seen[ST_DELETED],
                 status_seen[ST_NOT_FOUND], status_seen[ST_FULL], status_seen[ST_PRUNED]);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
